// ===== src/multi_channel_task_watchdog_macros.svh =====
// Assertion macros used by the watchdog core (mctw_core.sv)
`ifndef MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH
`define MULTI_CHANNEL_TASK_WATCHDOG_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define MCTW_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define MCTW_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MCTW_IMPLIES(lbl, clk_s, rst_s, ante, cons, msg)
`define MCTW_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ===== src/mctw_pkg.sv =====
// Shared constants, codes and types of the task watchdog
package mctw_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int REQ_W      = 2;
    localparam int TASK_W     = 6;
    localparam int TIME_W     = 32;
    localparam int EV_W       = 3;
    localparam int IVL_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int INFO_W     = TIME_W + 1;

    localparam logic [IVL_W-1:0] SCAN_INTERVAL_RST = 16'd1000;

    localparam logic [REQ_W-1:0] REQ_REGISTER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FEED     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROLLBACK_EN   = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_REGISTERED = 3'd0,
        EV_FULL       = 3'd1,
        EV_FED        = 3'd2,
        EV_BAD_ID     = 3'd3,
        EV_CRIT       = 3'd4,
        EV_TERM       = 3'd5,
        EV_TICK       = 3'd6
    } event_t;

    typedef struct packed {
        logic [IVL_W-1:0] scan_interval;
        logic             rollback_en;
    } cfg_t;

    typedef struct packed {
        event_t            event_res;
        logic [TASK_W-1:0] channel;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] limit;
        logic              rollback;
        logic              last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } res_word_t;

endpackage

// ===== src/mctw_req_if.sv =====
// Request channel: valid/ready handshake with the request word
interface mctw_req_if;
    import mctw_pkg::*;

    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [TASK_W-1:0] task_id;
    logic [TIME_W-1:0] timeout_len;
    logic              critical;

    modport source (output valid, output req_type, output task_id,
                    output timeout_len, output critical, input ready);
    modport sink   (input valid, input req_type, input task_id,
                    input timeout_len, input critical, output ready);
endinterface

// ===== src/mctw_res_if.sv =====
// Result channel: valid/ready handshake with the result word
interface mctw_res_if;
    import mctw_pkg::*;

    logic              valid;
    logic              ready;
    logic [EV_W-1:0]   event_res;
    logic [TASK_W-1:0] channel;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] limit;
    logic              rollback;
    logic              last;

    modport source (output valid, output event_res, output channel, output elapsed,
                    output limit, output rollback, output last, input ready);
    modport sink   (input valid, input event_res, input channel, input elapsed,
                    input limit, input rollback, input last, output ready);
endinterface

// ===== src/mctw_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module mctw_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== src/mctw_obuf.sv =====
// Output register stage between the sequencer and the result channel
module mctw_obuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mctw_pkg::res_word_t  word_in,
    output logic                 word_ready,
    mctw_res_if.source           res
);
    import mctw_pkg::*;

    logic    full_reg;
    result_t data_reg;

    assign word_ready = !full_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (word_ready)
        begin
            full_reg <= word_in.valid;
        end
    end

    // load a new word whenever the stage drains or is empty
    always_ff @(posedge clk)
    begin
        if (word_ready && word_in.valid)
        begin
            data_reg <= word_in.data;
        end
    end

    assign res.valid     = full_reg;
    assign res.event_res = data_reg.event_res;
    assign res.channel   = data_reg.channel;
    assign res.elapsed   = data_reg.elapsed;
    assign res.limit     = data_reg.limit;
    assign res.rollback  = data_reg.rollback;
    assign res.last      = data_reg.last;
endmodule

// ===== src/mctw_core.sv =====
// Request sequencer: channel table memories, time base and scan walk
`include "multi_channel_task_watchdog_macros.svh"
module mctw_core (
    input  logic                 clk,
    input  logic                 rst_n,
    mctw_req_if.sink             req,
    input  mctw_pkg::cfg_t       cfg,
    output mctw_pkg::res_word_t  res_word,
    input  logic                 res_ready
);
    import mctw_pkg::*;

    localparam int ID_W = TASK_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_SCAN_RD  = 4'b0010,
        ST_SCAN_CHK = 4'b0100,
        ST_EMIT     = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [IVL_W-1:0]       tts_reg, tts_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic [MAX_ENTRIES-1:0] active_reg, active_next;
    result_t                res_reg, res_next;

    logic              in_acc;
    logic              full;
    logic              id_ok;
    logic [IVL_W-1:0]  interval;
    logic [IVL_W:0]    tts_inc;
    logic              scan_due;
    logic [IDX_W-1:0]  idx_a;
    logic              last_entry;

    logic              stamp_we, info_we;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [TIME_W-1:0] rd_stamp;
    logic [INFO_W-1:0] rd_info;
    logic              rd_crit;
    logic [TIME_W-1:0] rd_limit;
    logic [TIME_W-1:0] elapsed_w;
    logic              hit;

    function automatic result_t mk_res(event_t ev, logic [TASK_W-1:0] ch,
                                       logic [TIME_W-1:0] el, logic [TIME_W-1:0] lim,
                                       logic rb, logic lst);
        result_t r;
        r.event_res = ev;
        r.channel   = ch;
        r.elapsed   = el;
        r.limit     = lim;
        r.rollback  = rb;
        r.last      = lst;
        return r;
    endfunction

    assign req.ready = (state_reg == ST_IDLE);
    assign in_acc    = req.valid && req.ready;

    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign id_ok    = {1'b0, req.task_id} < ID_W'(count_reg);
    assign interval = (cfg.scan_interval == '0) ? IVL_W'(1) : cfg.scan_interval;
    assign tts_inc  = {1'b0, tts_reg} + (IVL_W + 1)'(1);
    assign scan_due = tts_inc >= {1'b0, interval};

    assign idx_a      = scan_idx_reg[IDX_W-1:0];
    assign last_entry = (scan_idx_reg + CNT_W'(1)) == count_reg;

    assign rd_crit   = rd_info[INFO_W-1];
    assign rd_limit  = rd_info[TIME_W-1:0];
    assign elapsed_w = now_reg - rd_stamp;
    assign hit       = active_reg[idx_a] && (elapsed_w > rd_limit);

    // run the read one entry ahead while the walk finds nothing to report
    assign rd_addr = (state_reg == ST_SCAN_CHK && !hit) ? idx_a + IDX_W'(1) : idx_a;

    mctw_ram #(.WIDTH(TIME_W), .DEPTH(MAX_ENTRIES)) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_we),
        .wr_addr (wr_addr),
        .wr_data (now_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_stamp)
    );

    mctw_ram #(.WIDTH(INFO_W), .DEPTH(MAX_ENTRIES)) u_info_ram (
        .clk     (clk),
        .wr_en   (info_we),
        .wr_addr (wr_addr),
        .wr_data ({req.critical, req.timeout_len}),
        .rd_addr (rd_addr),
        .rd_data (rd_info)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        now_next      = now_reg;
        tts_next      = tts_reg;
        scan_idx_next = scan_idx_reg;
        active_next   = active_reg;
        res_next      = res_reg;
        stamp_we      = 1'b0;
        info_we       = 1'b0;
        wr_addr       = count_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (req.req_type)
                        REQ_REGISTER:
                        begin
                            if (!full)
                            begin
                                stamp_we = 1'b1;
                                info_we  = 1'b1;
                                active_next[count_reg[IDX_W-1:0]] = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                res_next = mk_res(EV_REGISTERED, TASK_W'(count_reg),
                                                  '0, '0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                res_next = mk_res(EV_FULL, '0, '0, '0, 1'b0, 1'b1);
                            end
                            state_next = ST_EMIT;
                        end
                        REQ_FEED:
                        begin
                            if (id_ok)
                            begin
                                stamp_we = 1'b1;
                                wr_addr  = req.task_id[IDX_W-1:0];
                                res_next = mk_res(EV_FED, req.task_id, '0, '0, 1'b0, 1'b1);
                            end
                            else
                            begin
                                res_next = mk_res(EV_BAD_ID, req.task_id, '0, '0, 1'b0, 1'b1);
                            end
                            state_next = ST_EMIT;
                        end
                        REQ_TICK:
                        begin
                            now_next = now_reg + TIME_W'(1);
                            res_next = mk_res(EV_TICK, '0, '0, '0, 1'b0, 1'b1);
                            if (scan_due)
                            begin
                                tts_next      = '0;
                                scan_idx_next = '0;
                                state_next    = (count_reg == '0) ? ST_EMIT : ST_SCAN_RD;
                            end
                            else
                            begin
                                tts_next   = tts_inc[IVL_W-1:0];
                                state_next = ST_EMIT;
                            end
                        end
                        default:
                        begin
                            // unused request code: drop the word
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (hit)
                begin
                    if (rd_crit)
                    begin
                        res_next = mk_res(EV_CRIT, TASK_W'(scan_idx_reg), elapsed_w,
                                          rd_limit, cfg.rollback_en, 1'b0);
                    end
                    else
                    begin
                        active_next[idx_a] = 1'b0;
                        res_next = mk_res(EV_TERM, TASK_W'(scan_idx_reg), elapsed_w,
                                          rd_limit, 1'b0, 1'b0);
                    end
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                    state_next    = ST_EMIT;
                end
                else if (last_entry)
                begin
                    res_next   = mk_res(EV_TICK, '0, '0, '0, 1'b0, 1'b1);
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    if (res_reg.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (scan_idx_reg == count_reg)
                    begin
                        // walk is over: close the tick
                        res_next = mk_res(EV_TICK, '0, '0, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        state_next = ST_SCAN_CHK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            now_reg      <= '0;
            tts_reg      <= '0;
            scan_idx_reg <= '0;
            active_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            now_reg      <= now_next;
            tts_reg      <= tts_next;
            scan_idx_reg <= scan_idx_next;
            active_reg   <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_word.valid = (state_reg == ST_EMIT);
    assign res_word.data  = res_reg;

    `MCTW_NEXT(a_reg_count_step, clk, rst_n, in_acc && req.req_type == REQ_REGISTER && !full, count_reg == $past(count_reg) + CNT_W'(1), "registration did not advance the channel count")
    `MCTW_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES), "channel count above table size")
    `MCTW_IMPLIES(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN_CHK, scan_idx_reg < count_reg, "scan index past registered channels")
    `MCTW_NEXT(a_term_clears_active, clk, rst_n, state_reg == ST_SCAN_CHK && hit && !rd_crit, !active_reg[$past(idx_a)], "terminated channel still active")
endmodule

// ===== src/multi_channel_task_watchdog.sv =====
// Top level of the multi-channel task watchdog
// Register and feed words: the result is registered in the core, then in the output
// stage. Tick words without a scan or with no channels emit a tick result; a scan
// over n > 0 channels walks the table by the single read port, one result per expiry.
// Reset: time, scan counter, channel count and active bits clear; scan interval
// returns to 1000 and rollback is disabled. No clearing pass is needed.
module multi_channel_task_watchdog (
    input  logic                            clk,
    input  logic                            rst_n,
    mctw_req_if.sink                        req,
    mctw_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [mctw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mctw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import mctw_pkg::*;

    cfg_t      cfg_reg;
    res_word_t res_word;
    logic      res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_interval <= SCAN_INTERVAL_RST;
            cfg_reg.rollback_en   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCAN_INTERVAL: cfg_reg.scan_interval <= cfg_wdata[IVL_W-1:0];
                CFG_ROLLBACK_EN:   cfg_reg.rollback_en   <= cfg_wdata[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    mctw_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg_reg),
        .res_word  (res_word),
        .res_ready (res_ready)
    );

    mctw_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_in    (res_word),
        .word_ready (res_ready),
        .res        (res)
    );
endmodule
